FILE: rtl/avr_alu_branch_step_top_assert.svh
// Assertion macros for the avr_alu_branch_step block.
// Used by the port checker; expects aclk and aresetn in scope.
`ifndef AVR_ALU_BRANCH_STEP_TOP_ASSERT_SVH
`define AVR_ALU_BRANCH_STEP_TOP_ASSERT_SVH

// checked only while out of reset
`define AABS_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked at every edge, reset included
`define AABS_CHK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/aabs_pkg.sv
// Package for the avr_alu_branch_step block: opcodes, branch kinds, flag
// positions, register file sizing and flag update functions. No dependencies.
package aabs_pkg;

    localparam int REG_COUNT   = 32;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int BANK_DEPTH  = REG_COUNT / 2;
    localparam int BANK_IDX_W  = REG_IDX_W - 1;
    localparam int PC_BITS_DEF = 16;
    localparam int OFF_W       = 12;

    localparam logic [REG_IDX_W-1:0] IMM_BASE = REG_IDX_W'(REG_COUNT / 2);

    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_ADC   = 5'd1;
    localparam logic [4:0] OP_AND   = 5'd2;
    localparam logic [4:0] OP_CP    = 5'd3;
    localparam logic [4:0] OP_CPC   = 5'd4;
    localparam logic [4:0] OP_EOR   = 5'd5;
    localparam logic [4:0] OP_OR    = 5'd6;
    localparam logic [4:0] OP_MOV   = 5'd7;
    localparam logic [4:0] OP_SBC   = 5'd8;
    localparam logic [4:0] OP_SUB   = 5'd9;
    localparam logic [4:0] OP_MUL   = 5'd10;
    localparam logic [4:0] OP_CLR   = 5'd11;
    localparam logic [4:0] OP_TST   = 5'd12;
    localparam logic [4:0] OP_LSL   = 5'd13;
    localparam logic [4:0] OP_ROL   = 5'd14;
    localparam logic [4:0] OP_RJMP  = 5'd15;
    localparam logic [4:0] OP_BR_LO = 5'd16;
    localparam logic [4:0] OP_BR_HI = 5'd21;
    localparam logic [4:0] OP_ANDI  = 5'd22;
    localparam logic [4:0] OP_LDI   = 5'd23;
    localparam logic [4:0] OP_CPI   = 5'd24;

    localparam logic [2:0] BR_EQ = 3'd0;
    localparam logic [2:0] BR_NE = 3'd1;
    localparam logic [2:0] BR_GE = 3'd2;
    localparam logic [2:0] BR_LT = 3'd3;
    localparam logic [2:0] BR_LO = 3'd4;
    localparam logic [2:0] BR_SH = 3'd5;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_N = 2;
    localparam int FL_V = 3;

    // write that left execute at the edge the next read was sampled
    typedef struct packed {
        logic                 wr;
        logic                 mul;
        logic [REG_IDX_W-1:0] addr;
        logic [7:0]           data;
        logic [15:0]          prod;
    } lw_t;

    function automatic logic [7:0] flags_arith(logic [7:0] sreg, logic [7:0] r,
                                               logic v, logic c, logic h, logic zmask);
        logic n;
        n = r[7];
        return {sreg[7:6], h, n ^ v, v, n, (r == 8'd0) & zmask, c};
    endfunction

    function automatic logic [7:0] flags_logic(logic [7:0] sreg, logic [7:0] r);
        return {sreg[7:5], r[7], 1'b0, r[7], r == 8'd0, sreg[FL_C]};
    endfunction

endpackage

FILE: rtl/avr_alu_branch_step_top.sv
// avr_alu_branch_step top level: AVR subset execute step with banked register file.
// Depends on aabs_pkg.
//
// Takes one decoded instruction per clock while s_ready is high and returns one
// result per instruction: the register file is read at the transfer edge, and
// the execute stage writes back registers, flags and PC and registers its result
// when that result moves to the output.
// Sustained rate is one instruction per cycle; the input stalls only while a
// finished result waits at the output and the execute stage is full. Registers
// live in two 16x8 banks (even and odd) so that mul writes r1:r0 in the same
// write; the previous instruction's write is forwarded into the read that
// overlapped it. Registers read as zero after reset through per-register valid
// bits, so no clearing pass is needed.
module avr_alu_branch_step_top
    import aabs_pkg::*;
#(
    parameter int PC_BITS = PC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [4:0]        s_req_type,
    input  logic [4:0]        s_dest_reg,
    input  logic [4:0]        s_src_reg,
    input  logic [7:0]        s_immediate,
    input  logic signed [11:0] s_offset,
    input  logic [2:0]        s_branch_kind,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_result_value,
    output logic              m_wrote_register,
    output logic [7:0]        m_status_flags,
    output logic [15:0]       m_next_pc
);

    localparam int DW = (PC_BITS > OFF_W) ? PC_BITS : OFF_W;

    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];

    logic                 s_fire, ex_fire, imm_in;
    logic [REG_IDX_W-1:0] ra_in;

    logic                 ex_valid_reg, haz_reg;
    logic [4:0]           ex_op_reg, ex_s_reg;
    logic [REG_IDX_W-1:0] ex_ra_reg;
    logic [7:0]           ex_k_reg;
    logic [11:0]          ex_off_reg;
    logic [2:0]           ex_kind_reg;
    logic [7:0]           rd_ae_reg, rd_ao_reg, rd_be_reg, rd_bo_reg;
    logic                 va_reg, vb_reg;
    logic [REG_COUNT-1:0] vld_reg;
    lw_t                  lw_reg, lw_next;

    logic [7:0]         sreg_reg, sreg_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;

    logic        m_valid_reg;
    logic [15:0] m_value_reg;
    logic        m_wrote_reg;
    logic [7:0]  m_flags_reg;
    logic [15:0] m_pc_reg;

    logic [7:0]    a, b, y, a_mem, b_mem, value8;
    logic          cin, c_add, c_sub, imm_ex, keep_z, taken, wr_any;
    logic [8:0]    sum9, sub9;
    logic [4:0]    hsum, hsub;
    logic [15:0]   prod, res16;
    logic [11:0]   delta12;
    logic [DW-1:0] delta_w;
    logic [7:0]    sh_r;

    assign ex_fire = ex_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !ex_valid_reg || ex_fire;
    assign s_fire  = s_valid && s_ready;

    assign imm_in = (s_req_type == OP_ANDI) || (s_req_type == OP_LDI) || (s_req_type == OP_CPI);
    assign ra_in  = imm_in ? (s_dest_reg | IMM_BASE) : s_dest_reg;

    // bank reads on transfer in
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_ae_reg <= even_mem[ra_in[REG_IDX_W-1:1]];
            rd_ao_reg <= odd_mem[ra_in[REG_IDX_W-1:1]];
            rd_be_reg <= even_mem[s_src_reg[REG_IDX_W-1:1]];
            rd_bo_reg <= odd_mem[s_src_reg[REG_IDX_W-1:1]];
        end
    end

    // even bank write
    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            if (lw_next.mul) begin
                even_mem[BANK_IDX_W'(0)] <= lw_next.prod[7:0];
            end else if (lw_next.wr && !lw_next.addr[0]) begin
                even_mem[lw_next.addr[REG_IDX_W-1:1]] <= lw_next.data;
            end
        end
    end

    // odd bank write
    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            if (lw_next.mul) begin
                odd_mem[BANK_IDX_W'(0)] <= lw_next.prod[15:8];
            end else if (lw_next.wr && lw_next.addr[0]) begin
                odd_mem[lw_next.addr[REG_IDX_W-1:1]] <= lw_next.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ex_op_reg   <= s_req_type;
            ex_ra_reg   <= ra_in;
            ex_s_reg    <= s_src_reg;
            ex_k_reg    <= s_immediate;
            ex_off_reg  <= s_offset;
            ex_kind_reg <= s_branch_kind;
        end
        if (ex_fire) begin
            m_value_reg <= res16;
            m_wrote_reg <= wr_any;
            m_flags_reg <= sreg_next;
            m_pc_reg    <= 16'(pc_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            haz_reg      <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vld_reg      <= '0;
            lw_reg.wr    <= 1'b0;
            lw_reg.mul   <= 1'b0;
            sreg_reg     <= '0;
            pc_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                ex_valid_reg <= 1'b1;
                haz_reg      <= ex_fire;
                va_reg       <= vld_reg[ra_in];
                vb_reg       <= vld_reg[s_src_reg];
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                lw_reg     <= lw_next;
                sreg_reg   <= sreg_next;
                pc_reg     <= pc_next;
                if (lw_next.mul) begin
                    vld_reg[0] <= 1'b1;
                    vld_reg[1] <= 1'b1;
                end else if (lw_next.wr) begin
                    vld_reg[lw_next.addr] <= 1'b1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // operand fetch with forwarding
    always_comb begin
        a_mem = (ex_ra_reg[0] ? rd_ao_reg : rd_ae_reg) & {8{va_reg}};
        b_mem = (ex_s_reg[0] ? rd_bo_reg : rd_be_reg) & {8{vb_reg}};
        a = a_mem;
        b = b_mem;
        if (haz_reg && lw_reg.mul) begin
            if (ex_ra_reg == REG_IDX_W'(0)) a = lw_reg.prod[7:0];
            if (ex_ra_reg == REG_IDX_W'(1)) a = lw_reg.prod[15:8];
            if (ex_s_reg == REG_IDX_W'(0))  b = lw_reg.prod[7:0];
            if (ex_s_reg == REG_IDX_W'(1))  b = lw_reg.prod[15:8];
        end else if (haz_reg && lw_reg.wr) begin
            if (ex_ra_reg == lw_reg.addr) a = lw_reg.data;
            if (ex_s_reg == lw_reg.addr)  b = lw_reg.data;
        end
    end

    always_comb begin
        cin    = sreg_reg[FL_C];
        imm_ex = (ex_op_reg == OP_ANDI) || (ex_op_reg == OP_CPI);
        y      = imm_ex ? ex_k_reg : b;
        c_add  = (ex_op_reg == OP_ADC) & cin;
        c_sub  = ((ex_op_reg == OP_CPC) || (ex_op_reg == OP_SBC)) & cin;
        keep_z = (ex_op_reg == OP_CPC) || (ex_op_reg == OP_SBC);
        sum9   = {1'b0, a} + {1'b0, y} + 9'(c_add);
        sub9   = {1'b0, a} - {1'b0, y} - 9'(c_sub);
        hsum   = {1'b0, a[3:0]} + {1'b0, y[3:0]} + 5'(c_add);
        hsub   = {1'b0, a[3:0]} - {1'b0, y[3:0]} - 5'(c_sub);
        prod   = a * b;
        sh_r   = {a[6:0], (ex_op_reg == OP_ROL) & cin};

        case (ex_kind_reg)
            BR_EQ:   taken = sreg_reg[FL_Z];
            BR_NE:   taken = !sreg_reg[FL_Z];
            BR_GE:   taken = !(sreg_reg[FL_N] ^ sreg_reg[FL_V]);
            BR_LT:   taken = sreg_reg[FL_N] ^ sreg_reg[FL_V];
            BR_LO:   taken = sreg_reg[FL_C];
            BR_SH:   taken = !sreg_reg[FL_C];
            default: taken = 1'b0;
        endcase

        value8       = 8'd0;
        sreg_next    = sreg_reg;
        delta12      = '0;
        lw_next.wr   = 1'b0;
        lw_next.mul  = 1'b0;
        lw_next.addr = ex_ra_reg;
        lw_next.prod = prod;

        unique case (ex_op_reg) inside
            OP_ADD, OP_ADC: begin
                value8     = sum9[7:0];
                lw_next.wr = 1'b1;
                sreg_next  = flags_arith(sreg_reg, sum9[7:0],
                                         ~(a[7] ^ y[7]) & (a[7] ^ sum9[7]),
                                         sum9[8], hsum[4], 1'b1);
            end
            OP_SUB, OP_SBC, OP_CP, OP_CPC, OP_CPI: begin
                value8     = sub9[7:0];
                lw_next.wr = (ex_op_reg == OP_SUB) || (ex_op_reg == OP_SBC);
                sreg_next  = flags_arith(sreg_reg, sub9[7:0],
                                         (a[7] ^ y[7]) & (a[7] ^ sub9[7]),
                                         sub9[8], hsub[4],
                                         !keep_z || sreg_reg[FL_Z]);
            end
            OP_AND, OP_ANDI, OP_EOR, OP_OR, OP_TST: begin
                case (ex_op_reg)
                    OP_EOR:  value8 = a ^ b;
                    OP_OR:   value8 = a | b;
                    OP_TST:  value8 = a;
                    default: value8 = a & y;
                endcase
                lw_next.wr = 1'b1;
                sreg_next  = flags_logic(sreg_reg, value8);
            end
            OP_CLR: begin
                lw_next.wr = 1'b1;
                sreg_next  = flags_logic(sreg_reg, 8'd0);
            end
            OP_MOV: begin
                value8     = b;
                lw_next.wr = 1'b1;
            end
            OP_LDI: begin
                value8     = ex_k_reg;
                lw_next.wr = 1'b1;
            end
            OP_LSL, OP_ROL: begin
                value8     = sh_r;
                lw_next.wr = 1'b1;
                sreg_next  = flags_arith(sreg_reg, sh_r, sh_r[7] ^ a[7], a[7], a[3], 1'b1);
            end
            OP_MUL: begin
                lw_next.mul      = 1'b1;
                sreg_next[FL_C]  = prod[15];
                sreg_next[FL_Z]  = (prod == 16'd0);
            end
            OP_RJMP: begin
                delta12 = ex_off_reg;
            end
            [OP_BR_LO:OP_BR_HI]: begin
                if (taken) delta12 = {{5{ex_off_reg[6]}}, ex_off_reg[6:0]};
            end
            default: begin
            end
        endcase

        lw_next.data = value8;
        wr_any  = lw_next.wr || lw_next.mul;
        res16   = lw_next.mul ? prod : (lw_next.wr ? {8'd0, value8} : 16'd0);
        delta_w = DW'($signed(delta12));
        pc_next = pc_reg + PC_BITS'(1) + delta_w[PC_BITS-1:0];
    end

    assign m_valid          = m_valid_reg;
    assign m_result_value   = m_value_reg;
    assign m_wrote_register = m_wrote_reg;
    assign m_status_flags   = m_flags_reg;
    assign m_next_pc        = m_pc_reg;

endmodule

FILE: rtl/aabs_checker.sv
// Port-level checker for avr_alu_branch_step_top, bound to the top level.
// Depends on avr_alu_branch_step_top_assert.svh.
`include "avr_alu_branch_step_top_assert.svh"

module aabs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_result_value,
    input logic        m_wrote_register,
    input logic [7:0]  m_status_flags,
    input logic [15:0] m_next_pc
);

    `AABS_CHK_RST(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")

    `AABS_CHK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_next_pc) && $stable(m_status_flags), "stalled result changed")

    `AABS_CHK(a_stall_only_when_full, !s_ready |-> m_valid && !m_ready, "input stalled with output free")

    `AABS_CHK(a_no_write_zero, m_valid && !m_wrote_register |-> m_result_value == 16'd0 && m_status_flags[7:6] == 2'd0, "bad result for no-write instruction")

endmodule

bind avr_alu_branch_step_top aabs_checker u_aabs_checker (.*);

FILE: test/tb_avr_alu_branch_step_top.sv
// Self-checking testbench for avr_alu_branch_step_top: directed table, then random
// instruction stream checked against an in-bench model of registers, SREG and PC.
// Depends on aabs_pkg and the avr_alu_branch_step_top RTL.
module tb_avr_alu_branch_step_top
    import aabs_pkg::*;
();

    localparam logic [4:0] OP_UNDEF_LO = 5'd25;
    localparam logic [4:0] OP_UNDEF_HI = 5'd31;
    localparam logic [2:0] BR_NONE_LO  = 3'd6;
    localparam logic [2:0] BR_NONE_HI  = 3'd7;
    localparam int RAND_ITEMS   = 750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [4:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rr;
        logic [7:0]  k;
        logic [11:0] off;
        logic [2:0]  kind;
    } instr_t;

    typedef struct packed {
        logic [15:0] value;
        logic        wrote;
        logic [7:0]  flags;
        logic [15:0] pc;
    } result_t;

    typedef struct packed {
        instr_t  ins;
        logic    typed;
        result_t res;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [4:0]  s_req_type = '0;
    logic [4:0]  s_dest_reg = '0;
    logic [4:0]  s_src_reg = '0;
    logic [7:0]  s_immediate = '0;
    logic [11:0] s_offset = '0;
    logic [2:0]  s_branch_kind = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_result_value;
    logic        m_wrote_register;
    logic [7:0]  m_status_flags;
    logic [15:0] m_next_pc;

    logic [7:0]  arch_regs [REG_COUNT];
    logic [7:0]  arch_sreg;
    logic [15:0] arch_pc;

    result_t pending_results [$];
    result_t head_res;
    row_t    dir_rows [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    bit      hold_active = 1'b0;
    bit      burst_in = 1'b0;

    avr_alu_branch_step_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_dest_reg      (s_dest_reg),
        .s_src_reg       (s_src_reg),
        .s_immediate     (s_immediate),
        .s_offset        (s_offset),
        .s_branch_kind   (s_branch_kind),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_wrote_register(m_wrote_register),
        .m_status_flags  (m_status_flags),
        .m_next_pc       (m_next_pc)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // SREG bits 5:0 are H S V N Z C; I and T never move
    task automatic alu_add(input logic [7:0] a, input logic [7:0] b, input logic c,
                           output logic [7:0] r);
        logic [8:0] sum;
        logic [4:0] half;
        logic       v;
        sum  = {1'b0, a} + {1'b0, b} + {8'd0, c};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
        r    = sum[7:0];
        v    = (a[7] ~^ b[7]) & (a[7] ^ r[7]);
        arch_sreg[5:0] = {half[4], r[7] ^ v, v, r[7], r == 8'd0, sum[8]};
    endtask

    task automatic alu_sub(input logic [7:0] a, input logic [7:0] b, input logic c,
                           input logic keep_z, output logic [7:0] r);
        logic [8:0] diff;
        logic       v, borrow, hb, z;
        diff   = {1'b0, a} - {1'b0, b} - {8'd0, c};
        r      = diff[7:0];
        v      = (a[7] ^ b[7]) & (a[7] ^ r[7]);
        borrow = {1'b0, a} < ({1'b0, b} + {8'd0, c});
        hb     = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, c});
        z      = (r == 8'd0) && (!keep_z || arch_sreg[FL_Z]);
        arch_sreg[5:0] = {hb, r[7] ^ v, v, r[7], z, borrow};
    endtask

    task automatic alu_logic(input logic [7:0] r);
        arch_sreg[4:1] = {r[7], 1'b0, r[7], r == 8'd0};
    endtask

    task automatic alu_shift(input logic [7:0] a, input logic c, output logic [7:0] r);
        logic ovf;
        r   = {a[6:0], c};
        ovf = r[7] ^ a[7];
        arch_sreg[5:0] = {a[3], r[7] ^ ovf, ovf, r[7], r == 8'd0, a[7]};
    endtask

    task automatic retire_instr(input instr_t ins, output result_t res);
        logic [7:0]  a, b, r, junk;
        logic [4:0]  di, widx;
        logic [15:0] prod, delta;
        logic        cin, wr, taken, is_mul;
        a      = arch_regs[ins.rd];
        b      = arch_regs[ins.rr];
        di     = ins.rd | IMM_BASE;
        widx   = ins.rd;
        cin    = arch_sreg[FL_C];
        r      = 8'd0;
        prod   = 16'd0;
        delta  = 16'd0;
        wr     = 1'b0;
        is_mul = 1'b0;
        taken  = 1'b0;
        case (ins.op)
            OP_ADD:  begin alu_add(a, b, 1'b0, r); wr = 1'b1; end
            OP_ADC:  begin alu_add(a, b, cin, r); wr = 1'b1; end
            OP_AND:  begin r = a & b; alu_logic(r); wr = 1'b1; end
            OP_CP:   alu_sub(a, b, 1'b0, 1'b0, junk);
            OP_CPC:  alu_sub(a, b, cin, 1'b1, junk);
            OP_EOR:  begin r = a ^ b; alu_logic(r); wr = 1'b1; end
            OP_OR:   begin r = a | b; alu_logic(r); wr = 1'b1; end
            OP_MOV:  begin r = b; wr = 1'b1; end
            OP_SBC:  begin alu_sub(a, b, cin, 1'b1, r); wr = 1'b1; end
            OP_SUB:  begin alu_sub(a, b, 1'b0, 1'b0, r); wr = 1'b1; end
            OP_MUL: begin
                prod = 16'(a) * 16'(b);
                arch_regs[0] = prod[7:0];
                arch_regs[1] = prod[15:8];
                arch_sreg[FL_C] = prod[15];
                arch_sreg[FL_Z] = (prod == 16'd0);
                is_mul = 1'b1;
            end
            OP_CLR:  begin r = 8'd0; arch_sreg[4:1] = 4'b0001; wr = 1'b1; end
            OP_TST:  begin r = a; alu_logic(r); wr = 1'b1; end
            OP_LSL:  begin alu_shift(a, 1'b0, r); wr = 1'b1; end
            OP_ROL:  begin alu_shift(a, cin, r); wr = 1'b1; end
            OP_RJMP: delta = {{4{ins.off[11]}}, ins.off};
            OP_ANDI: begin
                r = arch_regs[di] & ins.k;
                alu_logic(r);
                widx = di;
                wr = 1'b1;
            end
            OP_LDI:  begin r = ins.k; widx = di; wr = 1'b1; end
            OP_CPI:  alu_sub(arch_regs[di], ins.k, 1'b0, 1'b0, junk);
            default: begin
                if (ins.op >= OP_BR_LO && ins.op <= OP_BR_HI) begin
                    case (ins.kind)
                        BR_EQ:   taken = arch_sreg[FL_Z];
                        BR_NE:   taken = !arch_sreg[FL_Z];
                        BR_GE:   taken = !(arch_sreg[FL_N] ^ arch_sreg[FL_V]);
                        BR_LT:   taken = arch_sreg[FL_N] ^ arch_sreg[FL_V];
                        BR_LO:   taken = arch_sreg[FL_C];
                        BR_SH:   taken = !arch_sreg[FL_C];
                        default: taken = 1'b0;
                    endcase
                    if (taken) delta = {{9{ins.off[6]}}, ins.off[6:0]};
                end
            end
        endcase
        if (wr) arch_regs[widx] = r;
        arch_pc = arch_pc + 16'd1 + delta;
        res.value = is_mul ? prod : (wr ? {8'h00, r} : 16'h0000);
        res.wrote = wr | is_mul;
        res.flags = arch_sreg;
        res.pc    = arch_pc;
    endtask

    task automatic add_row(input logic [4:0] op, input logic [4:0] rd, input logic [4:0] rr,
                           input logic [7:0] k, input logic [11:0] off, input logic [2:0] kind,
                           input logic typed, input logic [15:0] value, input logic wrote,
                           input logic [7:0] flags, input logic [15:0] pc);
        row_t row;
        row.ins       = '{op: op, rd: rd, rr: rr, k: k, off: off, kind: kind};
        row.typed     = typed;
        row.res.value = value;
        row.res.wrote = wrote;
        row.res.flags = flags;
        row.res.pc    = pc;
        dir_rows.push_back(row);
    endtask

    task automatic send_instr(input instr_t ins, input logic typed, input result_t typed_res);
        result_t pred;
        int      gap;
        gap = (hold_active || burst_in) ? 0 : $urandom_range(0, 18);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= ins.op;
        s_dest_reg    <= ins.rd;
        s_src_reg     <= ins.rr;
        s_immediate   <= ins.k;
        s_offset      <= ins.off;
        s_branch_kind <= ins.kind;
        do @(posedge aclk); while (!s_ready);
        retire_instr(ins, pred);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else begin
            pending_results.push_back(pred);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected transfer: val=%h wr=%b fl=%h pc=%h",
                             m_result_value, m_wrote_register, m_status_flags, m_next_pc);
                mismatches++;
            end else begin
                head_res = pending_results.pop_front();
                if (head_res.value !== m_result_value || head_res.wrote !== m_wrote_register ||
                    head_res.flags !== m_status_flags || head_res.pc !== m_next_pc) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"mismatch: exp val=%h wr=%b fl=%h pc=%h, ",
                                  "got val=%h wr=%b fl=%h pc=%h"},
                                 head_res.value, head_res.wrote, head_res.flags, head_res.pc,
                                 m_result_value, m_wrote_register, m_status_flags, m_next_pc);
                    mismatches++;
                end
            end
        end
    end

    // result side: random stalls, bursts, and one long hold-off
    initial begin : rx_side
        int gap;
        int got;
        bit burst;
        got   = 0;
        burst = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (got == HOLD_AT) begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
                hold_active = 1'b0;
            end
            if ($urandom_range(0, 39) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 18);
            repeat (gap) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got++;
        end
    end

    initial begin : tx_side
        instr_t  ins;
        result_t none;
        int      sel;
        none = '0;
        for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = 8'h00;
        arch_sreg = 8'h00;
        arch_pc   = 16'h0000;

        // typed rows: state right after reset, an undefined opcode, LDI and ADD, and the rjmp extremes
        add_row(OP_CP,       5'd0,  5'd0,  8'h00, 12'h000, BR_EQ,      1'b1,
                16'h0000, 1'b0, 8'h02, 16'd1);
        add_row(OP_UNDEF_HI, 5'd31, 5'd31, 8'hFF, 12'hFFF, BR_NONE_HI, 1'b1,
                16'h0000, 1'b0, 8'h02, 16'd2);
        add_row(OP_LDI,      5'd0,  5'd0,  8'hFF, 12'h000, BR_EQ,      1'b1,
                16'h00FF, 1'b1, 8'h02, 16'd3);
        add_row(OP_LDI,      5'd17, 5'd0,  8'h01, 12'h000, BR_EQ,      1'b1,
                16'h0001, 1'b1, 8'h02, 16'd4);
        add_row(OP_ADD,      5'd16, 5'd17, 8'h00, 12'h000, BR_EQ,      1'b1,
                16'h0000, 1'b1, 8'h23, 16'd5);
        add_row(OP_RJMP,     5'd0,  5'd0,  8'h00, 12'h7FF, BR_EQ,      1'b1,
                16'h0000, 1'b0, 8'h23, 16'd2053);
        add_row(OP_RJMP,     5'd0,  5'd0,  8'h00, 12'h800, BR_EQ,      1'b1,
                16'h0000, 1'b0, 8'h23, 16'd6);
        // model-checked rows
        add_row(OP_UNDEF_LO, 5'd5,  5'd9,  8'h5A, 12'h123, BR_SH,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_LDI,      5'd31, 5'd0,  8'h80, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_ADC,      5'd17, 5'd31, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_SUB,      5'd31, 5'd17, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_SBC,      5'd16, 5'd31, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_CPC,      5'd17, 5'd16, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_CPI,      5'd15, 5'd0,  8'hFF, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_AND,      5'd31, 5'd17, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_OR,       5'd0,  5'd31, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_MUL,      5'd31, 5'd31, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_EOR,      5'd31, 5'd31, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_MOV,      5'd2,  5'd17, 8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_CLR,      5'd3,  5'd0,  8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_TST,      5'd17, 5'd0,  8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_LSL,      5'd17, 5'd0,  8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_ROL,      5'd17, 5'd0,  8'h00, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_ANDI,     5'd4,  5'd0,  8'h0F, 12'h000, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_BR_LO,    5'd0,  5'd0,  8'h00, 12'h03F, BR_EQ,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_BR_HI,    5'd0,  5'd0,  8'h00, 12'hFC0, BR_NE,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_BR_LO,    5'd0,  5'd0,  8'h00, 12'h040, BR_GE,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_BR_HI,    5'd0,  5'd0,  8'h00, 12'h001, BR_LT,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_BR_LO,    5'd0,  5'd0,  8'h00, 12'h07F, BR_LO,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_BR_HI,    5'd0,  5'd0,  8'h00, 12'hABC, BR_SH,      1'b0, '0, 1'b0, '0, '0);
        add_row(OP_BR_LO,    5'd0,  5'd0,  8'h00, 12'h010, BR_NONE_LO, 1'b0, '0, 1'b0, '0, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) send_instr(dir_rows[i].ins, dir_rows[i].typed, dir_rows[i].res);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) burst_in = !burst_in;
            sel = $urandom_range(0, 99);
            if (sel < 18) ins.op = OP_LDI;
            else if (sel < 24) ins.op = 5'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
            else if (sel < 40) ins.op = 5'($urandom_range(OP_RJMP, OP_BR_HI));
            else ins.op = 5'($urandom_range(OP_ADD, OP_CPI));
            ins.rd   = 5'($urandom);
            ins.rr   = 5'($urandom);
            ins.k    = 8'($urandom);
            ins.off  = 12'($urandom);
            ins.kind = 3'($urandom);
            send_instr(ins, 1'b0, none);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/aabs_pkg.sv
rtl/avr_alu_branch_step_top.sv
rtl/aabs_checker.sv
test/tb_avr_alu_branch_step_top.sv
